// ===== rtl/lss_pkg.sv =====
package lss_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_CNT_W  = 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_SCMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

// ===== rtl/lifo_stack_with_search.sv =====
// push and refused requests go from the start transfer straight to the done state;
// pop and peek read the top entry in S_TOP; a search steps through S_SCMP from the
// bottom entry up and stops at the first match or the top (at most the entry count)
// busy stays high through the done cycle, so a new request is taken only after done_o
// the search reads one entry per cycle; done_o marks each result for one cycle, no stall
// reset clears the sequencer and the entry count; the store contents are not reset
module lifo_stack_with_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] data_in_i,
  output logic        done_o,
  output logic [31:0] data_out_o,
  output logic        found_o,
  output logic [4:0]  count_o,
  output logic        empty_res_o,
  output logic [1:0]  status_o
);

  lss_pkg::state_e  state_q, state_d;
  lss_pkg::req_e    req_q, req_d;
  lss_pkg::word_t   key_q, key_d;
  lss_pkg::word_t   data_q, data_d;
  lss_pkg::addr_t   idx_q, idx_d;
  lss_pkg::cnt_t    cnt_q, cnt_d;
  lss_pkg::status_e status_q, status_d;
  logic             found_q, found_d;

  lss_pkg::mem_req_t mem_req;
  lss_pkg::word_t    rdata;
  lss_pkg::req_e     req_in;
  lss_pkg::word_t    word_in;

  logic accept;
  logic is_empty;
  logic is_full;
  logic hit;
  logic last;

  assign accept   = start && !busy;
  assign req_in   = lss_pkg::req_e'(req_type_i);
  assign word_in  = lss_pkg::word_t'(data_in_i);
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == lss_pkg::CNT_W'(lss_pkg::DEPTH));
  assign hit      = (rdata == key_q);
  assign last     = ((lss_pkg::CNT_W'(idx_q) + 1'b1) == cnt_q);

  lss_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lss_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_in) inside
            lss_pkg::REQ_POP, lss_pkg::REQ_PEEK: begin
              state_d = is_empty ? lss_pkg::S_DONE : lss_pkg::S_TOP;
            end
            lss_pkg::REQ_SEARCH: begin
              state_d = is_empty ? lss_pkg::S_DONE : lss_pkg::S_SCMP;
            end
            default: state_d = lss_pkg::S_DONE;
          endcase
        end
      end
      lss_pkg::S_TOP: state_d = lss_pkg::S_DONE;
      lss_pkg::S_SCMP: begin
        if (hit || last) begin
          state_d = lss_pkg::S_DONE;
        end
      end
      lss_pkg::S_DONE: state_d = lss_pkg::S_IDLE;
      default: state_d = lss_pkg::S_IDLE;
    endcase
  end

  // datapath and store port
  always_comb begin
    req_d         = req_q;
    key_d         = key_q;
    data_d        = data_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    status_d      = status_q;
    found_d       = found_q;
    mem_req.we    = 1'b0;
    mem_req.waddr = lss_pkg::ADDR_W'(cnt_q);
    mem_req.wdata = word_in;
    mem_req.raddr = lss_pkg::ADDR_W'(lss_pkg::CNT_W'(idx_q) + 1'b1);
    unique case (state_q)
      lss_pkg::S_IDLE: begin
        mem_req.raddr = '0;
        if (accept) begin
          req_d    = req_in;
          key_d    = word_in;
          data_d   = '0;
          idx_d    = '0;
          found_d  = 1'b0;
          status_d = lss_pkg::ST_OK;
          unique case (req_in) inside
            lss_pkg::REQ_PUSH: begin
              if (is_full) begin
                status_d = lss_pkg::ST_OVERFLOW;
              end else begin
                mem_req.we = 1'b1;
                cnt_d      = cnt_q + 1'b1;
              end
            end
            lss_pkg::REQ_POP, lss_pkg::REQ_PEEK: begin
              mem_req.raddr = lss_pkg::ADDR_W'(cnt_q - 1'b1);
              if (is_empty) begin
                status_d = lss_pkg::ST_UNDERFLOW;
              end else if (req_in == lss_pkg::REQ_POP) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      lss_pkg::S_TOP: data_d = rdata;
      lss_pkg::S_SCMP: begin
        if (hit) begin
          found_d = 1'b1;
        end else if (!last) begin
          idx_d = lss_pkg::ADDR_W'(lss_pkg::CNT_W'(idx_q) + 1'b1);
        end
      end
      lss_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lss_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    key_q    <= key_d;
    data_q   <= data_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  // outputs
  always_comb begin
    busy        = (state_q != lss_pkg::S_IDLE);
    done_o      = (state_q == lss_pkg::S_DONE);
    data_out_o  = lss_pkg::OUT_DATA_W'(data_q);
    found_o     = found_q && (req_q == lss_pkg::REQ_SEARCH);
    count_o     = lss_pkg::OUT_CNT_W'(cnt_q);
    empty_res_o = is_empty;
    status_o    = status_q;
  end

endmodule

// ===== rtl/lss_mem.sv =====
module lss_mem (
  input  logic              clk_i,
  input  lss_pkg::mem_req_t req_i,
  output lss_pkg::word_t    rdata_o
);

  lss_pkg::word_t mem_q [lss_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule
